/* src/btex_pkg.sv */
// Shared constants for the brick texture texel generator.
package btex_pkg;

  localparam int unsigned HashInW = 8;

  localparam logic [31:0] HashMulA = 32'd374761393;
  localparam logic [31:0] HashMulB = 32'd668265263;
  localparam logic [31:0] HashMulC = 32'd1274126177;

  localparam logic [7:0] AlphaOpaque = 8'hff;

  localparam logic [7:0] MortarRed   = 8'd62;
  localparam logic [7:0] MortarGreen = 8'd60;
  localparam logic [7:0] MortarBlue  = 8'd58;

  localparam logic [7:0] TintRedBase   = 8'd96;
  localparam logic [7:0] TintGreenBase = 8'd58;
  localparam logic [7:0] TintBlueBase  = 8'd46;

  localparam int unsigned MortarWidth = 3;

endpackage

/* src/btex_hash.sv */
// Two-stage pipelined coordinate hash with a folded output.
module btex_hash (
  input  logic                          clk,
  input  logic                          en,
  input  logic [btex_pkg::HashInW-1:0]  a,
  input  logic [btex_pkg::HashInW-1:0]  b,
  output logic [31:0]                   h
);
  import btex_pkg::*;

  logic [31:0] lin;
  logic [31:0] prod;
  logic [31:0] mix;

  assign mix = lin ^ (lin >> 13);
  assign h   = prod ^ (prod >> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      lin  <= 32'(a) * HashMulA + 32'(b) * HashMulB;
      prod <= mix * HashMulC;
    end
  end

endmodule

/* src/brick_texture_texel_generator.sv */
// Top level of the brick texture texel generator pipeline.
//
// One beat on the input channel carries a texel coordinate (column, row).
// One beat on the output channel carries that texel's packed color word,
// alpha in bits 31:24, blue 23:16, green 15:8, red 7:0.
// Both channels use valid and stall; a beat moves on a rising edge where
// valid is high and stall is low.
// The block is an eight-stage pipeline. A new coordinate can be taken
// every cycle while out_stall does not hold the pipeline, so the
// sustained rate is one texel per clock.
// The 32 by 32 bit hash multiplier sets the stage depth.
// When out_stall is high while a result waits, the whole pipeline holds
// and in_stall rises in the same cycle; no beat is lost or repeated.
// Reset clears every stage's valid bit; nothing else needs clearing.
module brick_texture_texel_generator #(
  parameter int unsigned TEXTURE_SIZE = 256,
  parameter int unsigned BRICK_WIDTH  = 64,
  parameter int unsigned BRICK_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  column,
  input  logic [7:0]  row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] texel_word
);
  import btex_pkg::*;

  localparam int unsigned Stages     = 7;
  localparam int unsigned ProdW      = 28;
  localparam int unsigned RecipShift = 21;
  localparam int unsigned CourseW    = 5;
  localparam int unsigned VqW        = 3;
  localparam int unsigned BqW        = 6;
  localparam int unsigned ShW        = 9;

  localparam logic [ProdW-1:0] RecipBh =
    ProdW'(((1 << RecipShift) + BRICK_HEIGHT - 1) / BRICK_HEIGHT);
  localparam logic [ProdW-1:0] RecipTs =
    ProdW'(((1 << RecipShift) + TEXTURE_SIZE - 1) / TEXTURE_SIZE);
  localparam logic [ProdW-1:0] RecipBw =
    ProdW'(((1 << RecipShift) + BRICK_WIDTH - 1) / BRICK_WIDTH);
  localparam logic [ShW-1:0] Stagger = ShW'(BRICK_WIDTH / 2);

  function automatic logic [7:0] clamp_ch(input logic signed [9:0] c);
    logic [7:0] r;
    if (c < 0) begin
      r = 8'd0;
    end else if (c > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = c[7:0];
    end
    return r;
  endfunction

  logic              adv;
  logic [Stages-1:0] vld;

  logic [7:0]         x1, y1;
  logic [CourseW-1:0] qy1;
  logic [CourseW-1:0] course2, course3, course4, course5;
  logic               my2, my3, my4, my5;
  logic [ShW-1:0]     v2, v3;
  logic [VqW-1:0]     vq3;
  logic [ShW-1:0]     sh4, sh5;
  logic [BqW-1:0]     bq5;
  logic [3:0]         grain3, grain4, grain5, grain6, grain7;
  logic               mortar6, mortar7;

  logic [15:0]        yrem;
  logic [15:0]        srem;
  logic [31:0]        hash_g;
  logic [31:0]        tint;

  logic signed [3:0]  gs;
  logic [7:0]         red, green, blue;
  logic [7:0]         red_c, green_c, blue_c;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign yrem = 16'(y1) - 16'(qy1) * 16'(BRICK_HEIGHT);
  assign srem = 16'(sh5) - 16'(bq5) * 16'(BRICK_WIDTH);

  btex_hash u_grain_hash (
    .clk (clk),
    .en  (adv),
    .a   (column),
    .b   (row),
    .h   (hash_g)
  );

  btex_hash u_tint_hash (
    .clk (clk),
    .en  (adv),
    .a   (HashInW'(bq5)),
    .b   (HashInW'(course5)),
    .h   (tint)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[Stages-2:0], in_valid};
      out_valid <= vld[Stages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1      <= column;
      y1      <= row;
      qy1     <= CourseW'((ProdW'(row) * RecipBh) >> RecipShift);

      course2 <= qy1;
      my2     <= yrem < 16'(MortarWidth);
      v2      <= ShW'(x1) + (qy1[0] ? Stagger : '0);

      v3      <= v2;
      vq3     <= VqW'((ProdW'(v2) * RecipTs) >> RecipShift);
      course3 <= course2;
      my3     <= my2;
      grain3  <= hash_g[3:0];

      sh4     <= ShW'(16'(v3) - 16'(vq3) * 16'(TEXTURE_SIZE));
      course4 <= course3;
      my4     <= my3;
      grain4  <= grain3;

      sh5     <= sh4;
      bq5     <= BqW'((ProdW'(sh4) * RecipBw) >> RecipShift);
      course5 <= course4;
      my5     <= my4;
      grain5  <= grain4;

      mortar6 <= my5 || (srem < 16'(MortarWidth));
      grain6  <= grain5;

      mortar7 <= mortar6;
      grain7  <= grain6;

      texel_word <= {AlphaOpaque, blue_c, green_c, red_c};
    end
  end

  always_comb begin
    gs = {~grain7[3], grain7[2:0]};
    if (mortar7) begin
      red   = MortarRed;
      green = MortarGreen;
      blue  = MortarBlue;
    end else begin
      red   = TintRedBase + 8'(tint[5:0]);
      green = TintGreenBase + 8'(tint[12:8]);
      blue  = TintBlueBase + 8'(tint[20:16]);
    end
    red_c   = clamp_ch($signed({2'b00, red}) + 10'(gs));
    green_c = clamp_ch($signed({2'b00, green}) + 10'(gs));
    blue_c  = clamp_ch($signed({2'b00, blue}) + 10'(gs));
  end

`ifndef SYNTH
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld) && $stable(out_valid))
    else $error("pipeline valid bits moved while the output was stalled");

  a_last_stage_moves_out: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[Stages-1]) |=> out_valid)
    else $error("a beat in the last stage did not reach the output");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (texel_word[31:24] == AlphaOpaque))
    else $error("output beat without opaque alpha");

  a_mortar_red: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[Stages-1] && mortar7) |=>
      (texel_word[7:0] >= 8'd54) && (texel_word[7:0] <= 8'd69))
    else $error("mortar texel red channel out of its grain band");
`endif

endmodule
